// ===== rtl/core/text_encoding_sniffer_core_macros.svh =====
// assertion helpers shared by the sniffer core files
`ifndef TEXT_ENCODING_SNIFFER_CORE_MACROS_SVH
`define TEXT_ENCODING_SNIFFER_CORE_MACROS_SVH

// checked only while out of reset
`define TES_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TES_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/tes_pkg.sv =====
// ----------------------------------------------------------------------------
// tes_pkg
// Types, byte constants and lead byte decode for the text encoding sniffer.
// ----------------------------------------------------------------------------
package tes_pkg;

  typedef enum logic [2:0] {
    ENC_ANSI     = 3'd0,
    ENC_UTF8     = 3'd1,
    ENC_UTF8_BOM = 3'd2,
    ENC_UTF16_LE = 3'd3,
    ENC_UTF16_BE = 3'd4
  } encoding_e;

  localparam logic [7:0] BYTE_FC = 8'hFC;
  localparam logic [7:0] BYTE_FD = 8'hFD;
  localparam logic [7:0] BYTE_F8 = 8'hF8;
  localparam logic [7:0] BYTE_F0 = 8'hF0;
  localparam logic [7:0] BYTE_E0 = 8'hE0;
  localparam logic [7:0] BYTE_C0 = 8'hC0;
  localparam logic [7:0] BYTE_80 = 8'h80;
  localparam logic [7:0] BYTE_FF = 8'hFF;
  localparam logic [7:0] BYTE_FE = 8'hFE;
  localparam logic [7:0] BYTE_EF = 8'hEF;
  localparam logic [7:0] BYTE_BB = 8'hBB;
  localparam logic [7:0] BYTE_BF = 8'hBF;

  localparam logic [2:0] HEAD_DEPTH = 3'd3;
  localparam logic [2:0] SEEN_MAX   = 3'd4;

  // one request moving from the input register into the tracker
  typedef struct packed {
    logic       fire;
    logic       has_byte;
    logic       is_last;
    logic [7:0] data_byte;
  } track_req_t;

  // continuation bytes owed by a lead byte of 0xC0 or above
  function automatic logic [2:0] lead_cont(input logic [7:0] b);
    logic [2:0] n;
    if (b == BYTE_FC || b == BYTE_FD) begin
      n = 3'd5;
    end else if (b >= BYTE_F8) begin
      n = 3'd4;
    end else if (b >= BYTE_F0) begin
      n = 3'd3;
    end else if (b >= BYTE_E0) begin
      n = 3'd2;
    end else begin
      n = 3'd1;
    end
    return n;
  endfunction

endpackage

// ===== rtl/core/text_encoding_sniffer_core.sv =====
// ----------------------------------------------------------------------------
// text_encoding_sniffer_core
// Byte-stream text encoding sniffer with utf-8 check and byte order mark match.
// ----------------------------------------------------------------------------
// One byte per request, one request per cycle. The request is registered, the
// tracker updates its state from it, and on a request marked last the verdict
// is written to the result register as the request leaves the input register.
// Input stall rises only while a last request sits in the input register and
// the result register still holds an untaken verdict.
`include "text_encoding_sniffer_core_macros.svh"

module text_encoding_sniffer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       has_byte_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] encoding_o
);

  logic                 s1_valid_q;
  logic [7:0]           s1_byte_q;
  logic                 s1_has_q;
  logic                 s1_last_q;
  logic                 s1_fire;
  logic                 out_free;
  logic                 in_take;
  logic                 out_valid_q;
  tes_pkg::encoding_e   encoding_q;
  tes_pkg::encoding_e   verdict;
  tes_pkg::track_req_t  req;

  assign out_free   = !out_valid_q || !out_stall_i;
  // only a last request needs room in the result register
  assign s1_fire    = s1_valid_q && (!s1_last_q || out_free);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_take    = in_valid_i && !in_stall_o;

  assign req.fire      = s1_fire;
  assign req.has_byte  = s1_has_q;
  assign req.is_last   = s1_last_q;
  assign req.data_byte = s1_byte_q;

  tes_track u_track (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .verdict_o (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire && s1_last_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= data_byte_i;
      s1_has_q  <= has_byte_i;
      s1_last_q <= is_last_i;
    end
    if (s1_fire && s1_last_q) begin
      encoding_q <= verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign encoding_o  = 3'(encoding_q);

  `TES_ASSERT(a_stall_only_on_last, clk_i, rst_ni,
    in_stall_o |-> s1_valid_q && s1_last_q && out_valid_q && out_stall_i,
    "input stalled without a blocked last request")

  `TES_ASSERT(a_last_gives_result, clk_i, rst_ni,
    s1_fire && s1_last_q |=> out_valid_q,
    "last request produced no result")

  `TES_ASSERT(a_nonlast_moves, clk_i, rst_ni,
    s1_valid_q && !s1_last_q |-> s1_fire,
    "non-last request held in input register")

endmodule

// ===== rtl/core/tes_track.sv =====
// ----------------------------------------------------------------------------
// tes_track
// Per-buffer utf-8 structure state, head bytes and verdict logic.
// ----------------------------------------------------------------------------
`include "text_encoding_sniffer_core_macros.svh"

module tes_track (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tes_pkg::track_req_t   req_i,
  output tes_pkg::encoding_e    verdict_o
);

  logic [2:0] cont_left_q, cont_left_d, cont_upd;
  logic       all_ascii_q, all_ascii_d, ascii_upd;
  logic       seen_invalid_q, seen_invalid_d, invalid_upd;
  logic [2:0] bytes_seen_q, bytes_seen_d, bytes_upd;
  logic [7:0] head_q [3];
  logic       take;

  assign take = req_i.fire && req_i.has_byte;

  // state after the byte of this request, before any end-of-buffer clear
  always_comb begin
    cont_upd    = cont_left_q;
    ascii_upd   = all_ascii_q;
    invalid_upd = seen_invalid_q;
    bytes_upd   = bytes_seen_q;
    if (take) begin
      if (bytes_seen_q < tes_pkg::SEEN_MAX) begin
        bytes_upd = bytes_seen_q + 3'd1;
      end
      if (req_i.data_byte[7]) begin
        ascii_upd = 1'b0;
      end
      if (!seen_invalid_q) begin
        if (cont_left_q == 3'd0) begin
          if (req_i.data_byte >= tes_pkg::BYTE_C0) begin
            cont_upd = tes_pkg::lead_cont(req_i.data_byte);
          end else if (req_i.data_byte >= tes_pkg::BYTE_80) begin
            invalid_upd = 1'b1;
          end
        end else if ((req_i.data_byte & tes_pkg::BYTE_C0) != tes_pkg::BYTE_80) begin
          invalid_upd = 1'b1;
        end else begin
          cont_upd = cont_left_q - 3'd1;
        end
      end
    end
  end

  always_comb begin
    if (req_i.fire && req_i.is_last) begin
      cont_left_d    = 3'd0;
      all_ascii_d    = 1'b1;
      seen_invalid_d = 1'b0;
      bytes_seen_d   = 3'd0;
    end else begin
      cont_left_d    = cont_upd;
      all_ascii_d    = ascii_upd;
      seen_invalid_d = invalid_upd;
      bytes_seen_d   = bytes_upd;
    end
  end

  // the head bytes that the marks need are already stored when the count allows a match
  always_comb begin
    if (bytes_upd >= tes_pkg::HEAD_DEPTH && head_q[0] == tes_pkg::BYTE_FF &&
        head_q[1] == tes_pkg::BYTE_FE) begin
      verdict_o = tes_pkg::ENC_UTF16_LE;
    end else if (bytes_upd >= tes_pkg::HEAD_DEPTH && head_q[0] == tes_pkg::BYTE_FE &&
                 head_q[1] == tes_pkg::BYTE_FF) begin
      verdict_o = tes_pkg::ENC_UTF16_BE;
    end else if (bytes_upd >= tes_pkg::SEEN_MAX && head_q[0] == tes_pkg::BYTE_EF &&
                 head_q[1] == tes_pkg::BYTE_BB && head_q[2] == tes_pkg::BYTE_BF) begin
      verdict_o = tes_pkg::ENC_UTF8_BOM;
    end else if (invalid_upd || cont_upd != 3'd0 || ascii_upd) begin
      verdict_o = tes_pkg::ENC_ANSI;
    end else begin
      verdict_o = tes_pkg::ENC_UTF8;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cont_left_q    <= 3'd0;
      all_ascii_q    <= 1'b1;
      seen_invalid_q <= 1'b0;
      bytes_seen_q   <= 3'd0;
    end else begin
      cont_left_q    <= cont_left_d;
      all_ascii_q    <= all_ascii_d;
      seen_invalid_q <= seen_invalid_d;
      bytes_seen_q   <= bytes_seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && bytes_seen_q < tes_pkg::HEAD_DEPTH) begin
      head_q[bytes_seen_q[1:0]] <= req_i.data_byte;
    end
  end

  `TES_ASSERT(a_clear_after_last, clk_i, rst_ni,
    req_i.fire && req_i.is_last |=> cont_left_q == 3'd0 && all_ascii_q &&
    !seen_invalid_q && bytes_seen_q == 3'd0,
    "state not cleared after end of buffer")

  `TES_ASSERT_ALWAYS(a_owed_not_ascii, clk_i,
    cont_left_q != 3'd0 |-> !all_ascii_q,
    "continuation owed while buffer still all ascii")

  `TES_ASSERT(a_count_saturates, clk_i, rst_ni,
    bytes_seen_q == tes_pkg::SEEN_MAX && !(req_i.fire && req_i.is_last)
    |=> bytes_seen_q == tes_pkg::SEEN_MAX,
    "byte count left saturation")

  `TES_ASSERT(a_idle_holds, clk_i, rst_ni,
    !req_i.fire |=> $stable(cont_left_q) && $stable(bytes_seen_q) &&
    $stable(seen_invalid_q),
    "tracker state moved without a request")

endmodule

// ===== tb/tes_verdict_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tes_verdict_checker
// Watches both channels of the sniffer core. It tracks the utf-8 structure and
// the head bytes of each buffer, predicts the verdict of every request marked
// last, and compares it with the encoding that leaves the core.
// ----------------------------------------------------------------------------
module tes_verdict_checker
  import tes_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        is_last_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  encoding_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);

  encoding_e   verdict_q[$];
  int unsigned bad_total;

  logic [2:0] owed;
  logic       ascii_only;
  logic       broken;
  logic [2:0] taken;
  logic [7:0] head [3];

  function automatic void clear_tracking();
    owed       = 3'd0;
    ascii_only = 1'b1;
    broken     = 1'b0;
    taken      = 3'd0;
    head[0]    = 8'h00;
    head[1]    = 8'h00;
    head[2]    = 8'h00;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [7:0] b;
    encoding_e  enc;
    encoding_e  want;
    if (!rst_ni) begin
      clear_tracking();
      verdict_q.delete();
      bad_total = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        if (has_byte_i) begin
          b = data_byte_i;
          if (taken < HEAD_DEPTH) begin
            head[taken[1:0]] = b;
          end
          if (taken < SEEN_MAX) begin
            taken = taken + 3'd1;
          end
          if (b[7]) begin
            ascii_only = 1'b0;
          end
          // structure tracking freezes once the buffer is known to be broken
          if (!broken) begin
            if (owed == 3'd0) begin
              casez (b)
                8'b0???????: ;
                8'b10??????: broken = 1'b1;
                8'b110?????: owed = 3'd1;
                8'b1110????: owed = 3'd2;
                8'b11110???: owed = 3'd3;
                8'b1111110?: owed = 3'd5;
                default:     owed = 3'd4; // f8..fb and fe, ff
              endcase
            end else if (b[7:6] != 2'b10) begin
              broken = 1'b1;
            end else begin
              owed = owed - 3'd1;
            end
          end
        end
        if (is_last_i) begin
          if (taken >= HEAD_DEPTH && head[0] == BYTE_FF && head[1] == BYTE_FE) begin
            enc = ENC_UTF16_LE;
          end else if (taken >= HEAD_DEPTH && head[0] == BYTE_FE && head[1] == BYTE_FF) begin
            enc = ENC_UTF16_BE;
          end else if (taken >= SEEN_MAX && head[0] == BYTE_EF && head[1] == BYTE_BB &&
                       head[2] == BYTE_BF) begin
            enc = ENC_UTF8_BOM;
          end else if (broken || owed != 3'd0 || ascii_only) begin
            enc = ENC_ANSI;
          end else begin
            enc = ENC_UTF8;
          end
          verdict_q.push_back(enc);
          clear_tracking();
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          $error("encoding: expected none, actual %0d", encoding_i);
          bad_total++;
        end else begin
          want = verdict_q.pop_front();
          if (encoding_i !== want) begin
            $error("encoding: expected %0d, actual %0d", want, encoding_i);
            bad_total++;
          end
        end
      end
      mismatches_o <= bad_total;
      pending_o    <= verdict_q.size();
    end
  end

endmodule

// ===== tb/tb_text_encoding_sniffer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_encoding_sniffer_core
// Drives buffers into the sniffer core: a directed set of byte order marks,
// utf-8 forms and broken buffers, then random buffers that are mostly well
// formed utf-8 with random content, plus noise. Verdicts are checked beside
// the core by the checker module.
// ----------------------------------------------------------------------------
module tb_text_encoding_sniffer_core;
  import tes_pkg::*;

  localparam int ITEM_TARGET  = 1550;
  localparam int CALM_TAIL    = 200;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] data_byte_i = 8'h00;
  logic       has_byte_i  = 1'b0;
  logic       is_last_i   = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [2:0] encoding_o;

  int unsigned mismatch_count;
  int unsigned verdicts_pending;
  bit          idle_on      = 1'b0;
  int unsigned items_sent   = 0;
  int unsigned quiet_cycles = 0;
  int          stall_left   = 0;
  logic [7:0]  buf_q[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  text_encoding_sniffer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .has_byte_i  (has_byte_i),
    .is_last_i   (is_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .encoding_o  (encoding_o)
  );

  tes_verdict_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .has_byte_i   (has_byte_i),
    .is_last_i    (is_last_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .encoding_i   (encoding_o),
    .mismatches_o (mismatch_count),
    .pending_o    (verdicts_pending)
  );

  // receiver stalls in bursts, started at random while idle_on is set
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [7:0] b, input logic h, input logic l);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    has_byte_i  <= h;
    is_last_i   <= l;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (h || l) begin
      items_sent++;
    end
  endtask

  // one buffer; the last byte carries the end marker unless an end-only request closes it
  task automatic send_buffer(input logic [7:0] octets[$], input bit end_only);
    int n;
    n = octets.size();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        send_request(8'($urandom), 1'b0, 1'b0);
      end
      send_request(octets[i], 1'b1, !end_only && i == n - 1);
    end
    if (end_only || n == 0) begin
      send_request(8'($urandom), 1'b0, 1'b1);
    end
  endtask

  initial begin : stimulus
    int shape;
    int n;
    int pick;
    logic [7:0] lead;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty buffer, then an idle request ahead of a lone ascii byte
    buf_q.delete();
    send_buffer(buf_q, 1'b1);
    send_request(8'hA5, 1'b0, 1'b0);
    buf_q = '{8'h41};
    send_buffer(buf_q, 1'b0);
    // utf-16 marks on three bytes
    buf_q = '{8'hFF, 8'hFE, 8'h00};
    send_buffer(buf_q, 1'b0);
    buf_q = '{8'hFE, 8'hFF, 8'h7F};
    send_buffer(buf_q, 1'b0);
    // utf-8 mark needs a fourth byte, without it the mark is plain utf-8
    buf_q = '{8'hEF, 8'hBB, 8'hBF, 8'h41};
    send_buffer(buf_q, 1'b0);
    buf_q = '{8'hEF, 8'hBB, 8'hBF};
    send_buffer(buf_q, 1'b1);
    // stray continuation as lead byte
    buf_q = '{8'h80};
    send_buffer(buf_q, 1'b0);
    // longest lead form with its five continuations
    buf_q = '{8'hFC, 8'h80, 8'hBF, 8'h80, 8'h80, 8'hBF};
    send_buffer(buf_q, 1'b0);

    // hold off until every verdict so far is back
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (verdicts_pending != 0) @(posedge clk_i);

    while (items_sent < ITEM_TARGET) begin
      idle_on = (items_sent < ITEM_TARGET - CALM_TAIL) && ($urandom_range(0, 9) != 0);
      buf_q.delete();
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
        n = $urandom_range(0, 8);
        repeat (n) buf_q.push_back(8'($urandom));
      end else if (shape == 1) begin
        // short buffers around the mark lengths
        n = $urandom_range(0, 4);
        repeat (n) begin
          pick = $urandom_range(0, 5);
          case (pick)
            0: buf_q.push_back(BYTE_FF);
            1: buf_q.push_back(BYTE_FE);
            2: buf_q.push_back(BYTE_EF);
            3: buf_q.push_back(BYTE_BB);
            4: buf_q.push_back(BYTE_BF);
            default: buf_q.push_back(8'($urandom));
          endcase
        end
      end else begin
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
          buf_q = '{BYTE_EF, BYTE_BB, BYTE_BF};
        end else if (pick == 1) begin
          buf_q = '{BYTE_FF, BYTE_FE};
        end else if (pick == 2) begin
          buf_q = '{BYTE_FE, BYTE_FF};
        end
        n = $urandom_range(0, 10);
        repeat (n) begin
          pick = $urandom_range(0, 6);
          if (pick <= 1) begin
            buf_q.push_back({1'b0, 7'($urandom)});
          end else begin
            case (pick)
              2: lead = {3'b110, 5'($urandom)};
              3: lead = {4'b1110, 4'($urandom)};
              4: lead = {5'b11110, 3'($urandom)};
              5: lead = ($urandom_range(0, 2) == 0) ? {7'b1111111, 1'($urandom)}
                                                      : {6'b111110, 2'($urandom)};
              default: lead = {7'b1111110, 1'($urandom)};
            endcase
            buf_q.push_back(lead);
            // fe and ff owe four, same as f8..fb
            repeat ((pick == 6) ? 5 : pick - 1) buf_q.push_back({2'b10, 6'($urandom)});
          end
        end
        // damage a few: a random byte somewhere, or a truncated tail
        if (shape == 2 && buf_q.size() > 0) begin
          if ($urandom_range(0, 1) == 0) begin
            buf_q[$urandom_range(0, buf_q.size() - 1)] = 8'($urandom);
          end else begin
            void'(buf_q.pop_back());
          end
        end
      end
      send_buffer(buf_q, $urandom_range(0, 3) == 0);
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (verdicts_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
